// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the request gate.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Check a consequent in the cycle after a sequence completes
`define ASSERT_SEQ_NEXT(lbl, clk, rst_n, seq, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (seq) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/tbrg_pkg.sv =====
// ----------------------------------------------------------------------------
// tbrg_pkg
// Types, codes and helpers shared by the token bucket request gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbrg_pkg;

	// Sizes
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CMD_DEPTH       = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int TOK_W           = 7;
	localparam int PKT_W           = 16;
	localparam int PERIOD_W        = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REFILL_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFILL_AMOUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS_ALL    = 2'd3;

	// Input commands
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// Result outcomes
	localparam logic [1:0] OC_PASSED   = 2'd0;
	localparam logic [1:0] OC_QUEUED   = 2'd1;
	localparam logic [1:0] OC_RELEASED = 2'd2;
	localparam logic [1:0] OC_DROPPED  = 2'd3;

	// Register reset values
	localparam logic [TOK_W-1:0]    RST_BUCKET_SIZE   = 7'd8;
	localparam logic [PERIOD_W-1:0] RST_REFILL_PERIOD = 16'd16;
	localparam logic [TOK_W-1:0]    RST_REFILL_AMOUNT = 7'd4;
	localparam logic                RST_BYPASS_ALL    = 1'b1;

	typedef struct packed {
		logic [TOK_W-1:0]    bucket_size;
		logic [PERIOD_W-1:0] refill_period;
		logic [TOK_W-1:0]    refill_amount;
		logic                bypass_all;
	} cfg_t;

	// Entry of the command queue between front and back
	typedef struct packed {
		logic             refill;
		logic [PKT_W-1:0] pkt;
	} qent_t;

	// Back-end status seen by the top level
	typedef struct packed {
		logic             draining;
		logic [TOK_W-1:0] tokens;
	} gate_stat_t;

	// Refill amount clipped to the bucket size
	function automatic logic [TOK_W-1:0] f_eff(input cfg_t c);
		return (c.refill_amount < c.bucket_size) ? c.refill_amount : c.bucket_size;
	endfunction

endpackage

// ===== hdl/tbrg_front.sv =====
// ----------------------------------------------------------------------------
// tbrg_front
// Accepts input beats, counts ticks against the refill period and forwards
// requests and refill events to the command queue. Plain ticks end here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbrg_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [tbrg_pkg::PKT_W-1:0]  packet_id,
	input  tbrg_pkg::cfg_t              cfg,
	input  logic                        cfg_we,
	input  logic                        q_full,
	output logic                        q_push,
	output tbrg_pkg::qent_t             q_ent
);
	import tbrg_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] period_eff;
	logic [PERIOD_W-1:0] period_nxt;
	logic                refill_hit;
	logic                accept;

	// Classify the incoming beat
	always_comb begin
		period_eff = (cfg.refill_period == '0) ? PERIOD_W'(1) : cfg.refill_period;
		period_nxt = period_q + PERIOD_W'(1);
		refill_hit = (period_nxt >= period_eff) || (period_nxt == '0);
		in_stall   = q_full;
		accept     = in_valid && !q_full;
		q_push     = accept && ((command == CMD_REQUEST) || refill_hit);
		q_ent.refill = (command == CMD_TICK);
		q_ent.pkt    = packet_id;
	end

	// Advance the period counter on ticks, restart it on config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
		end else if (cfg_we) begin
			period_q <= '0;
		end else if (accept && (command == CMD_TICK)) begin
			period_q <= refill_hit ? '0 : period_nxt;
		end
	end

endmodule

// ===== hdl/tbrg_cmdq.sv =====
// ----------------------------------------------------------------------------
// tbrg_cmdq
// Short in-order command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbrg_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tbrg_pkg::qent_t push_ent,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output tbrg_pkg::qent_t head_ent
);
	import tbrg_pkg::*;

	localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CW = $clog2(CMD_DEPTH + 1);

	qent_t         ent_q [CMD_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p);
		return (p == PW'(CMD_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_comb begin
		full     = (cnt_q == CW'(CMD_DEPTH));
		valid    = (cnt_q != '0);
		head_ent = ent_q[rd_q];
		do_push  = push && !full;
		do_pop   = pop && valid;
	end

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_ent;
		end
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= f_adv(wr_q);
			end
			if (do_pop) begin
				rd_q <= f_adv(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/tbrg_back.sv =====
// ----------------------------------------------------------------------------
// tbrg_back
// Token accounting, wait FIFO and result register. Takes one queued command
// at a time; a refill drains waiting requests, one read and one emit each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbrg_back #(
	parameter int QUEUE_DEPTH = tbrg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tbrg_pkg::cfg_t              cfg,
	input  logic                        reload,
	input  logic                        q_valid,
	input  tbrg_pkg::qent_t             q_ent,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tbrg_pkg::PKT_W-1:0]  result_packet,
	output logic [1:0]                  outcome,
	output logic                        last,
	output tbrg_pkg::gate_stat_t        stat
);
	import tbrg_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [PKT_W-1:0] mem [QUEUE_DEPTH];
	logic [PKT_W-1:0] rd_data_q;
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    cnt_q;
	logic [TOK_W-1:0] tok_q;
	logic [1:0]       state_q;
	logic             out_valid_q;

	logic [TOK_W-1:0] eff;
	logic             full_refill;
	logic             slot_free;
	logic             can_take;
	logic [TOK_W-1:0] tok_dec;
	logic [TOK_W:0]   tok_sum;
	logic [TOK_W-1:0] tok_ref;
	logic             ref_go;
	logic [CW-1:0]    cnt_dec;
	logic             rel_more;
	logic             has_room;
	logic             wr_en;
	logic             emit;
	logic             take_req;
	logic             set_valid;

	function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// Token decisions
	always_comb begin
		eff         = f_eff(cfg);
		full_refill = (eff == cfg.bucket_size);
		slot_free   = !out_valid_q || !out_stall;
		q_pop       = (state_q == ST_IDLE) && slot_free && q_valid && !reload;
		take_req    = q_pop && !q_ent.refill;
		can_take    = cfg.bypass_all || (tok_q != '0) || full_refill;
		tok_dec     = (cfg.bypass_all || (tok_q == '0)) ? tok_q : tok_q - TOK_W'(1);
		tok_sum     = {1'b0, tok_q} + {1'b0, eff};
		tok_ref     = (tok_sum < {1'b0, cfg.bucket_size}) ? tok_sum[TOK_W-1:0]
		                                                 : cfg.bucket_size;
		ref_go      = (cnt_q != '0) &&
		              (cfg.bypass_all || (tok_ref != '0) || full_refill);
		cnt_dec     = cnt_q - CW'(1);
		rel_more    = (cnt_dec != '0) &&
		              (cfg.bypass_all || (tok_dec != '0) || full_refill);
		has_room    = (cnt_q < CW'(QUEUE_DEPTH));
		wr_en       = take_req && !can_take && has_room;
		emit        = (state_q == ST_EMIT) && slot_free;
		set_valid   = take_req || (emit && !reload);
	end

	// Wait FIFO storage with registered head read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= q_ent.pkt;
		end
		rd_data_q <= mem[head_q];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			tok_q       <= RST_REFILL_AMOUNT;
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// Raise on a new beat, hold while stalled, else drop
			out_valid_q <= set_valid || (out_valid_q && !slot_free);
			if (reload) begin
				tok_q <= eff;
			end else if (q_pop) begin
				if (q_ent.refill) begin
					tok_q   <= tok_ref;
					state_q <= ref_go ? ST_RD : ST_IDLE;
				end else begin
					if (can_take) begin
						tok_q <= tok_dec;
					end else if (has_room) begin
						tail_q <= f_adv(tail_q);
						cnt_q  <= cnt_q + CW'(1);
					end
				end
			end else if (state_q == ST_RD) begin
				state_q <= ST_EMIT;
			end else if (emit) begin
				tok_q       <= tok_dec;
				head_q      <= f_adv(head_q);
				cnt_q       <= cnt_dec;
				state_q     <= rel_more ? ST_RD : ST_IDLE;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take_req) begin
			result_packet <= q_ent.pkt;
			last          <= 1'b1;
			if (can_take) begin
				outcome <= OC_PASSED;
			end else if (has_room) begin
				outcome <= OC_QUEUED;
			end else begin
				outcome <= OC_DROPPED;
			end
		end else if (emit) begin
			result_packet <= rd_data_q;
			outcome       <= OC_RELEASED;
			last          <= !rel_more;
		end
	end

	always_comb begin
		out_valid     = out_valid_q;
		stat.draining = (state_q != ST_IDLE);
		stat.tokens   = tok_q;
	end

endmodule

// ===== hdl/token_bucket_request_gate.sv =====
// ----------------------------------------------------------------------------
// token_bucket_request_gate
// A request result passes the command queue, then the result register.
// Throughput: one request per cycle, set by the back end taking one queued
// command per cycle while it is idle, the output is not stalled and no
// token reload is pending; each released request takes a wait FIFO read,
// then an emit. Reset clears all control state, loads register defaults and
// four tokens; wait FIFO contents stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module token_bucket_request_gate #(
	parameter int QUEUE_DEPTH = tbrg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [tbrg_pkg::PKT_W-1:0]      packet_id,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [tbrg_pkg::PKT_W-1:0]      result_packet,
	output logic [1:0]                      outcome,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [tbrg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbrg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tbrg_pkg::*;

	cfg_t       cfg_q;
	logic       reload_q;
	logic       reg_hit;
	logic       q_full;
	logic       q_push;
	qent_t      q_push_ent;
	logic       q_pop;
	logic       q_valid;
	qent_t      q_head_ent;
	gate_stat_t gate_stat;

	// Decode a known register index
	always_comb begin
		case (cfg_index)
			REG_BUCKET_SIZE, REG_REFILL_PERIOD,
			REG_REFILL_AMOUNT, REG_BYPASS_ALL: reg_hit = 1'b1;
			default:                           reg_hit = 1'b0;
		endcase
	end

	// Hold configuration; flag a token reload after any write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bucket_size   <= RST_BUCKET_SIZE;
			cfg_q.refill_period <= RST_REFILL_PERIOD;
			cfg_q.refill_amount <= RST_REFILL_AMOUNT;
			cfg_q.bypass_all    <= RST_BYPASS_ALL;
			reload_q            <= 1'b0;
		end else begin
			reload_q <= cfg_we && reg_hit;
			if (cfg_we) begin
				case (cfg_index)
					REG_BUCKET_SIZE:   cfg_q.bucket_size   <= cfg_data[TOK_W-1:0];
					REG_REFILL_PERIOD: cfg_q.refill_period <= cfg_data[PERIOD_W-1:0];
					REG_REFILL_AMOUNT: cfg_q.refill_amount <= cfg_data[TOK_W-1:0];
					REG_BYPASS_ALL:    cfg_q.bypass_all    <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	tbrg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.packet_id (packet_id),
		.cfg       (cfg_q),
		.cfg_we    (cfg_we && reg_hit),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_ent     (q_push_ent)
	);

	tbrg_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (q_push_ent),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_ent (q_head_ent)
	);

	tbrg_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.reload        (reload_q),
		.q_valid       (q_valid),
		.q_ent         (q_head_ent),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_packet (result_packet),
		.outcome       (outcome),
		.last          (last),
		.stat          (gate_stat)
	);

	// A beat that is not the last of its input comes from a refill drain
	`ASSERT_IMPLY(a_partial_is_release, clk, arst_n, out_valid && !last, outcome == OC_RELEASED)
	`ASSERT_IMPLY(a_partial_while_drain, clk, arst_n, out_valid && !last, gate_stat.draining)
	// A lone config write leaves the bucket at the clipped refill amount
	`ASSERT_SEQ_NEXT(a_reload_tokens, clk, arst_n, cfg_we ##1 !cfg_we, gate_stat.tokens == f_eff(cfg_q))

endmodule
